// File: rtl/core/igs_pkg.sv
// Shared types and constants for the interval greedy selector.
`timescale 1ns / 1ps

package igs_pkg;

  // Width of the time fields on the ports
  localparam int TIME_W = 16;

  // Default store depth and number of significant time bits
  localparam int DEF_MAX_INTERVALS = 64;
  localparam int DEF_TIME_BITS     = 16;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } igs_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic in_ready;    // take input items
    logic scan_clear;  // restart the scan: address to zero, drop best candidate
    logic rd_issue;    // read the store at the scan address and advance it
    logic keep;        // best candidate becomes the pending result
    logic finish;      // emit pending result as final and close the set
  } igs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_fire;     // item accepted this cycle
    logic in_last;     // accepted item closes the set
    logic last_issue;  // scan address points at the last stored entry
    logic best_vld;    // scan found a candidate
    logic pend_vld;    // a result is held back for its final flag
    logic out_free;    // output register can take a result this cycle
  } igs_sts_t;

endpackage

// File: rtl/core/igs_ctrl.sv
// Controller state machine of the interval greedy selector.
`timescale 1ns / 1ps

module igs_ctrl
  import igs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  igs_sts_t sts,
  output igs_cmd_t cmd
);

  igs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_LOAD: begin
        cmd.in_ready = 1'b1;
        if (sts.in_fire && sts.in_last) begin
          cmd.scan_clear = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_issue = 1'b1;
        if (sts.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.best_vld) begin
          // hold until the previous pending result can move out
          if (!sts.pend_vld || sts.out_free) begin
            cmd.keep       = 1'b1;
            cmd.scan_clear = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

// File: rtl/core/igs_dpath.sv
// Datapath of the interval greedy selector: store, scan compare, output register.
`timescale 1ns / 1ps

module igs_dpath
  import igs_pkg::*;
#(
  parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
  parameter int TIME_BITS     = DEF_TIME_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic [2*TIME_W-1:0] in_tdata,
  input  logic                in_tlast,
  input  igs_cmd_t            cmd,
  output igs_sts_t            sts,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [2*TIME_W-1:0] out_tdata,
  output logic                out_tlast,
  output logic                out_tuser
);

  localparam int SW = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  localparam int IW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int KW = 2 * SW + IW;

  // Store entries are {end, start}
  logic [2*SW-1:0] mem [MAX_INTERVALS];

  logic [CW-1:0]   count_r, count_nxt;
  logic            ovf_r, ovf_nxt;
  logic            any_kept_r, any_kept_nxt;
  logic [KW-1:0]   last_key_r;
  logic [IW-1:0]   rd_idx_r;
  logic            rd_vld_r;
  logic [IW-1:0]   rd_tag_r;
  logic [2*SW-1:0] rd_data_r;
  logic            best_vld_r;
  logic [KW-1:0]   best_key_r;
  logic            pend_vld_r;
  logic [SW-1:0]   pend_s_r, pend_e_r;
  logic            out_vld_r;
  logic [SW-1:0]   out_s_r, out_e_r;
  logic            out_fin_r, out_ovf_r;

  logic            in_fire;
  logic            store_full;
  logic [KW-1:0]   cand_key;
  logic [SW-1:0]   cand_s;
  logic [SW-1:0]   last_e;
  logic            cand_ok;
  logic            out_free;
  logic            out_load;

  assign in_fire    = in_tvalid && cmd.in_ready;
  assign store_full = (count_r == CW'(MAX_INTERVALS));
  assign out_free   = !out_vld_r || out_tready;
  assign out_load   = (cmd.keep && pend_vld_r) || cmd.finish;

  // Candidate key orders by end, then start, then load position
  assign cand_key = {rd_data_r, rd_tag_r};
  assign cand_s   = rd_data_r[SW-1:0];
  assign last_e   = last_key_r[KW-1 -: SW];
  assign cand_ok  = rd_vld_r
                    && (!any_kept_r || ((cand_s >= last_e) && (cand_key > last_key_r)))
                    && (!best_vld_r || (cand_key < best_key_r));

  always_comb begin
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    any_kept_nxt = any_kept_r;
    if (in_fire) begin
      if (store_full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
    if (cmd.keep) begin
      any_kept_nxt = 1'b1;
    end
    if (cmd.finish) begin
      count_nxt    = '0;
      ovf_nxt      = 1'b0;
      any_kept_nxt = 1'b0;
    end
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (in_fire && !store_full) begin
      mem[count_r[IW-1:0]] <= {in_tdata[TIME_W +: SW], in_tdata[SW-1:0]};
    end
    rd_data_r <= mem[rd_idx_r];
    rd_tag_r  <= rd_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ovf_r      <= 1'b0;
      any_kept_r <= 1'b0;
      rd_idx_r   <= '0;
      rd_vld_r   <= 1'b0;
      best_vld_r <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      any_kept_r <= any_kept_nxt;
      rd_vld_r   <= cmd.rd_issue;
      if (cmd.scan_clear) begin
        rd_idx_r <= '0;
      end else if (cmd.rd_issue) begin
        rd_idx_r <= rd_idx_r + IW'(1);
      end
      if (cmd.scan_clear) begin
        best_vld_r <= 1'b0;
      end else if (cand_ok) begin
        best_vld_r <= 1'b1;
      end
      if (cmd.keep) begin
        pend_vld_r <= 1'b1;
      end else if (cmd.finish) begin
        pend_vld_r <= 1'b0;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cand_ok && !cmd.scan_clear) begin
      best_key_r <= cand_key;
    end
    if (cmd.keep) begin
      last_key_r <= best_key_r;
      pend_s_r   <= best_key_r[IW +: SW];
      pend_e_r   <= best_key_r[KW-1 -: SW];
    end
    if (out_load) begin
      out_s_r   <= pend_s_r;
      out_e_r   <= pend_e_r;
      out_fin_r <= cmd.finish;
      out_ovf_r <= ovf_r;
    end
  end

  always_comb begin
    sts            = '0;
    sts.in_fire    = in_fire;
    sts.in_last    = in_tlast;
    sts.last_issue = (CW'(rd_idx_r) == (count_r - CW'(1)));
    sts.best_vld   = best_vld_r;
    sts.pend_vld   = pend_vld_r;
    sts.out_free   = out_free;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {TIME_W'(out_e_r), TIME_W'(out_s_r)};
  assign out_tlast  = out_fin_r;
  assign out_tuser  = out_ovf_r;

endmodule

// File: rtl/core/interval_greedy_selector_top.sv
// Top level of the interval greedy selector.
`timescale 1ns / 1ps

// Greedy interval selection. Intervals stream in one item per cycle (start and
// end time); the item with tlast closes the set. Up to MAX_INTERVALS intervals
// are stored; items beyond that are dropped and every result of the set then
// carries the overflow flag in out_tuser. The set is ordered by end time, then
// start time, then arrival order, and an interval is kept when none has been
// kept yet or its start is not before the end of the one kept last. Kept
// intervals leave in that order, the last one marked with out_tlast.
// After the closing item the block runs one scan of the store per kept interval
// plus one closing scan. Each scan reads the store one entry per cycle through
// its single read port, then passes a compare stage and a decide state, which
// waits for a free output register whenever a result has to move into it.
// in_tready is low from the closing item until the final result has entered the
// output register; one result waits in the output register without stalling
// the next scan.

module interval_greedy_selector_top
  import igs_pkg::*;
#(
  parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
  parameter int TIME_BITS     = DEF_TIME_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [2*TIME_W-1:0] in_tdata,   // [15:0] start_time, [31:16] end_time
  input  logic                in_tlast,   // set_last
  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [2*TIME_W-1:0] out_tdata,  // [15:0] kept_start, [31:16] kept_end
  output logic                out_tlast,  // final_kept
  output logic                out_tuser   // overflowed
);

  igs_cmd_t cmd;
  igs_sts_t sts;

  igs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  igs_dpath #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .TIME_BITS     (TIME_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Take items only while loading
  assign in_tready = cmd.in_ready;

endmodule

// File: sim/interval_greedy_selector_top_tb.sv
// Testbench for the interval greedy selector: directed table, random sets, scoreboard.
`timescale 1ns / 1ps

module interval_greedy_selector_top_tb;
  import igs_pkg::*;

  localparam int CAP        = DEF_MAX_INTERVALS;
  localparam int IDLE_LIMIT = 3000;  // no-progress watchdog; a full set scans the whole store per result
  localparam int TAIL_WAIT  = 200;

  // One selected interval as it leaves the block
  typedef struct {
    logic [TIME_W-1:0] ks;
    logic [TIME_W-1:0] ke;
    logic              fin;
    logic              ovf;
  } kept_t;

  // One row of the directed table; typed rows carry their own expectation
  typedef struct {
    logic [TIME_W-1:0] s;
    logic [TIME_W-1:0] e;
    logic              last;
    bit                typed;
    kept_t             want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [2*TIME_W-1:0] in_tdata = '0;
  logic                in_tlast = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [2*TIME_W-1:0] out_tdata;
  logic                out_tlast;
  logic                out_tuser;

  // Intervals of the open set, as the block should hold them
  logic [TIME_W-1:0] held_s [CAP];
  logic [TIME_W-1:0] held_e [CAP];
  int                held_n = 0;
  logic              held_ovf = 1'b0;

  kept_t    kept_q [$];   // selected intervals still to come out
  dir_row_t dir_q  [$];

  int err_count = 0;
  int n_items   = 0;
  int n_sets    = 0;
  int n_ovf     = 0;
  int n_results = 0;
  int idle_cnt  = 0;
  int rx_wait   = 0;
  bit tx_calm   = 1'b0;
  bit rx_calm   = 1'b0;

  interval_greedy_selector_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h (t=%0t)", what, got, want, $realtime);
    err_count++;
  endtask

  // Store one interval; on the closing item sort the set by end, then start,
  // and queue the greedy selection. The last kept interval is held back so
  // that it can carry the final flag.
  task automatic take_interval(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e,
                               input logic last, input bit emit);
    int                i;
    int                j;
    logic [TIME_W-1:0] ts;
    logic [TIME_W-1:0] te;
    logic [TIME_W-1:0] end_mark;
    bit                have;
    kept_t             pend;
    if (held_n < CAP) begin
      held_s[held_n] = s;
      held_e[held_n] = e;
      held_n++;
    end else begin
      held_ovf = 1'b1;
    end
    if (!last) return;
    for (i = 1; i < held_n; i++) begin
      ts = held_s[i];
      te = held_e[i];
      j = i;
      while (j > 0 && (te < held_e[j-1] || (te == held_e[j-1] && ts < held_s[j-1]))) begin
        held_s[j] = held_s[j-1];
        held_e[j] = held_e[j-1];
        j--;
      end
      held_s[j] = ts;
      held_e[j] = te;
    end
    have = 1'b0;
    end_mark = '0;
    for (i = 0; i < held_n; i++) begin
      if (!have || held_s[i] >= end_mark) begin
        if (have && emit) kept_q.insert(kept_q.size(), pend);
        pend.ks = held_s[i];
        pend.ke = held_e[i];
        pend.fin = 1'b0;
        pend.ovf = held_ovf;
        have = 1'b1;
        end_mark = held_e[i];
      end
    end
    pend.fin = 1'b1;
    if (have && emit) kept_q.insert(kept_q.size(), pend);
    n_sets++;
    if (held_ovf) n_ovf++;
    held_n = 0;
    held_ovf = 1'b0;
  endtask

  // Present one item after a random gap and hold it until the block takes it
  task automatic drive_interval(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e,
                                input logic last, input bit emit);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      // drop valid and put junk on the bus while idle
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      in_tlast  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {e, s};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    take_interval(s, e, last, emit);
    n_items++;
  endtask

  task automatic add_row(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e,
                         input logic last, input bit typed,
                         input logic [TIME_W-1:0] ws, input logic [TIME_W-1:0] we);
    dir_row_t r;
    r.s = s;
    r.e = e;
    r.last = last;
    r.typed = typed;
    r.want.ks = ws;
    r.want.ke = we;
    r.want.fin = 1'b1;
    r.want.ovf = 1'b0;
    dir_q.insert(dir_q.size(), r);
  endtask

  function automatic logic [TIME_W-1:0] pick_time(input int mode);
    case (mode)
      0, 1:    pick_time = TIME_W'($urandom_range(0, 40));
      2:       pick_time = TIME_W'($urandom_range(0, 65535));
      default: begin
        case ($urandom_range(0, 2))
          0:       pick_time = '0;
          1:       pick_time = '1;
          default: pick_time = TIME_W'($urandom_range(65500, 65535));
        endcase
      end
    endcase
  endfunction

  // Result side: random stalls, scoreboard check, no-progress watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
      idle_cnt = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (kept_q.size() == 0) begin
          report_mismatch("unexpected result", {out_tuser, out_tlast, out_tdata[29:0]}, '0);
        end else begin
          if (out_tdata[15:0] !== kept_q[0].ks)
            report_mismatch("kept_start", 32'(out_tdata[15:0]), 32'(kept_q[0].ks));
          if (out_tdata[31:16] !== kept_q[0].ke)
            report_mismatch("kept_end", 32'(out_tdata[31:16]), 32'(kept_q[0].ke));
          if (out_tlast !== kept_q[0].fin)
            report_mismatch("final_kept", 32'(out_tlast), 32'(kept_q[0].fin));
          if (out_tuser !== kept_q[0].ovf)
            report_mismatch("overflowed", 32'(out_tuser), 32'(kept_q[0].ovf));
          void'(kept_q.pop_front());
        end
        if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 14);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_tready <= (rx_wait == 0);

      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int        set_no;
    int        rnd_items;
    int        size;
    int        mode;
    int        k;
    logic [TIME_W-1:0] s;
    logic [TIME_W-1:0] e;
    dir_row_t  r;

    // Single-interval sets: the one interval comes back as the final result
    add_row(16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'h0000);
    add_row(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
    add_row(16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'hFFFF, 16'h0000);  // end before start
    add_row(16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 16'hFFFF);
    add_row(16'hAAAA, 16'h5555, 1'b1, 1'b1, 16'hAAAA, 16'h5555);
    add_row(16'h5555, 16'hAAAA, 1'b1, 1'b1, 16'h5555, 16'hAAAA);
    // overlapping set
    add_row(16'd1, 16'd10, 1'b0, 1'b0, '0, '0);
    add_row(16'd2, 16'd5,  1'b0, 1'b0, '0, '0);
    add_row(16'd5, 16'd8,  1'b1, 1'b0, '0, '0);
    // equal end times, ties broken by start
    add_row(16'd3, 16'd7, 1'b0, 1'b0, '0, '0);
    add_row(16'd1, 16'd7, 1'b0, 1'b0, '0, '0);
    add_row(16'd7, 16'd9, 1'b1, 1'b0, '0, '0);
    // duplicate zero-length intervals
    add_row(16'd4, 16'd4, 1'b0, 1'b0, '0, '0);
    add_row(16'd4, 16'd4, 1'b1, 1'b0, '0, '0);
    // zeros
    add_row(16'd0, 16'd0, 1'b0, 1'b0, '0, '0);
    add_row(16'd0, 16'd0, 1'b0, 1'b0, '0, '0);
    add_row(16'd0, 16'd5, 1'b1, 1'b0, '0, '0);
    // extremes inside one set
    add_row(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0, '0);
    add_row(16'h0000, 16'hFFFF, 1'b1, 1'b0, '0, '0);
    // reversed interval among normal ones
    add_row(16'd9, 16'd2, 1'b0, 1'b0, '0, '0);
    add_row(16'd3, 16'd6, 1'b1, 1'b0, '0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (dir_q[i]) begin
      r = dir_q[i];
      drive_interval(r.s, r.e, r.last, !r.typed);
      if (r.typed) kept_q.insert(kept_q.size(), r.want);
    end

    // Hold off until the block has drained everything
    in_tvalid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);

    // Random sets: mostly small, a few at and past the store capacity
    set_no = 0;
    rnd_items = 0;
    while (rnd_items < 230 || set_no <= 8) begin
      case (set_no)
        2:       size = CAP;      // exactly full
        5:       size = CAP + 1;  // closing item itself is dropped
        8:       size = CAP + 6;
        default: begin
          k = $urandom_range(0, 9);
          if (k < 6)      size = $urandom_range(1, 6);
          else if (k < 9) size = $urandom_range(7, 16);
          else            size = $urandom_range(17, 40);
        end
      endcase
      mode = $urandom_range(0, 3);
      for (k = 0; k < size; k++) begin
        s = pick_time(mode);
        if ($urandom_range(0, 7) == 0) e = pick_time(mode);
        else e = s + TIME_W'($urandom_range(0, (mode == 2) ? 4000 : 12));
        drive_interval(s, e, (k == size - 1), 1'b1);
      end
      rnd_items += size;
      if ($urandom_range(0, 9) == 0) begin
        in_tvalid <= 1'b0;
        while (kept_q.size() != 0) @(posedge clk);
      end
      set_no++;
    end
    in_tvalid <= 1'b0;

    while (kept_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (kept_q.size() != 0) report_mismatch("results missing", '0, 32'(kept_q.size()));

    $display("Covered %0d intervals in %0d sets (%0d with store overflow),", n_items, n_sets,
             n_ovf);
    $display("with %0d selected intervals checked under random stalls on both sides.",
             n_results);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
